### rtl/mbea_pkg.sv
// Shared constants, types and the bit gather function of the masked bit extract accumulator.
`timescale 1ns / 1ps
`default_nettype none
package mbea_pkg;

  localparam int unsigned INDEX_BITS = 24;
  localparam int unsigned BUCKET_BITS = 16;

  localparam int unsigned INDEX_W = 24;
  localparam int unsigned MASK_W = 24;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BUCKET_FIELD_W = 16;

  localparam int unsigned EXT_BITS = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
  localparam int unsigned POS_W = $clog2(EXT_BITS + 1);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MASK_W-1:0] MASK_RESET = 24'hF3DEF;

  localparam logic CMD_ACC = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN = 1'b1;

  typedef struct packed {
    logic                   acc;
    logic [BUCKET_BITS-1:0] bucket;
    logic [VALUE_W-1:0]     value;
  } entry_t;

  // Parallel bit extract: the lowest selected index bit lands in bucket bit 0.
  function automatic logic [BUCKET_BITS-1:0] gather(input logic [EXT_BITS-1:0] idx,
                                                    input logic [EXT_BITS-1:0] mask);
    logic [BUCKET_BITS-1:0] res;
    logic [POS_W-1:0]       pos;
    res = '0;
    for (int i = 0; i < EXT_BITS; i++) begin
      pos = POS_W'($countones(mask & ((EXT_BITS'(1) << i) - EXT_BITS'(1))));
      for (int j = 0; j < BUCKET_BITS; j++) begin
        if (mask[i] && (j < EXT_BITS) && (pos == POS_W'(j))) begin
          res[j] = res[j] | idx[i];
        end
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/masked_bit_extract_accumulate_core.sv
// Top level of the masked bit extract accumulator: front end, entry queue and back end.
// Path of an item: front end register, entry queue, back end read stage, output register.
// The back end takes no new entry while the read-modify-write of the last one is in flight.
// After reset all 2^BUCKET_BITS (65536) buckets are cleared to zero with busy high.
// Results cannot be stalled by the receiver; each is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module masked_bit_extract_accumulate_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 cmd_i,
  input  wire logic [mbea_pkg::INDEX_W-1:0]         source_index_i,
  input  wire logic signed [mbea_pkg::VALUE_W-1:0]  sample_value_i,
  input  wire logic [mbea_pkg::BUCKET_FIELD_W-1:0]  read_bucket_i,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [mbea_pkg::MASK_W-1:0]          cfg_data_i,
  output logic                                      out_strobe_o,
  output logic [mbea_pkg::BUCKET_FIELD_W-1:0]       bucket_index_o,
  output logic signed [mbea_pkg::VALUE_W-1:0]       bucket_sum_o
);

  logic                          accept;
  logic                          front_ready;
  logic                          push;
  logic                          pop;
  logic                          fifo_full;
  logic                          fifo_empty;
  logic                          clearing;
  mbea_pkg::entry_t              front_entry;
  mbea_pkg::entry_t              head_entry;
  logic [mbea_pkg::VALUE_W-1:0]  sum_raw;

  assign busy         = clearing || !front_ready;
  assign accept       = start && !busy;
  assign cfg_ready_o  = 1'b1;
  assign bucket_sum_o = sum_raw;

  mbea_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .source_index_i (source_index_i),
    .sample_value_i (sample_value_i),
    .read_bucket_i  (read_bucket_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .entry_o        (front_entry),
    .ready_o        (front_ready)
  );

  mbea_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  mbea_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_entry),
    .empty_i        (fifo_empty),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .out_strobe_o   (out_strobe_o),
    .bucket_index_o (bucket_index_o),
    .bucket_sum_o   (sum_raw)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> busy)
    else $error("An item could be accepted while the bucket memory is being cleared.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> !out_strobe_o)
    else $error("A result was issued while the bucket memory is being cleared.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_strobe_o |=> !out_strobe_o)
    else $error("Results were issued faster than the read-modify-write allows.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !fifo_full)
    else $error("The entry queue was written while full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_empty && !clearing)
    else $error("The back end took an entry that was not there.");
`endif

endmodule
`default_nettype wire

### rtl/mbea_front.sv
// Front end: holds the select mask, accepts items and turns them into queue entries.
`timescale 1ns / 1ps
`default_nettype none
module mbea_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire logic                               cmd_i,
  input  wire logic [mbea_pkg::INDEX_W-1:0]       source_index_i,
  input  wire logic [mbea_pkg::VALUE_W-1:0]       sample_value_i,
  input  wire logic [mbea_pkg::BUCKET_FIELD_W-1:0] read_bucket_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [mbea_pkg::MASK_W-1:0]        cfg_data_i,
  input  wire logic                               fifo_full_i,
  output logic                                    push_o,
  output mbea_pkg::entry_t                        entry_o,
  output logic                                    ready_o
);

  logic [mbea_pkg::MASK_W-1:0] mask_q;
  logic                        valid_q;
  logic                        valid_d;
  mbea_pkg::entry_t            entry_q;
  mbea_pkg::entry_t            entry_d;

  assign push_o  = valid_q && !fifo_full_i;
  assign ready_o = !valid_q || push_o;
  assign entry_o = entry_q;

  always_comb begin
    valid_d = accept_i || (valid_q && !push_o);
    entry_d.acc = (cmd_i == mbea_pkg::CMD_ACC);
    entry_d.value = sample_value_i;
    if (cmd_i == mbea_pkg::CMD_ACC) begin
      entry_d.bucket = mbea_pkg::gather(source_index_i[mbea_pkg::EXT_BITS-1:0],
                                        mask_q[mbea_pkg::EXT_BITS-1:0]);
    end else begin
      entry_d.bucket = mbea_pkg::BUCKET_BITS'(read_bucket_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= mbea_pkg::MASK_RESET;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mask_q <= cfg_data_i;
      end
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      entry_q <= entry_d;
    end
  end

endmodule
`default_nettype wire

### rtl/mbea_fifo.sv
// Short queue of classified entries between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module mbea_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mbea_pkg::entry_t entry_i,
  input  wire logic             pop_i,
  output mbea_pkg::entry_t      head_o,
  output logic                  full_o,
  output logic                  empty_o
);

  mbea_pkg::entry_t            store_q [mbea_pkg::QUEUE_DEPTH];
  logic [mbea_pkg::QPTR_W-1:0] wr_ptr_q;
  logic [mbea_pkg::QPTR_W-1:0] wr_ptr_d;
  logic [mbea_pkg::QPTR_W-1:0] rd_ptr_q;
  logic [mbea_pkg::QPTR_W-1:0] rd_ptr_d;
  logic [mbea_pkg::QCNT_W-1:0] cnt_q;
  logic [mbea_pkg::QCNT_W-1:0] cnt_d;

  assign full_o  = (cnt_q == mbea_pkg::QCNT_W'(mbea_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mbea_pkg::QPTR_W'(mbea_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + mbea_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mbea_pkg::QPTR_W'(mbea_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + mbea_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + mbea_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - mbea_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

### rtl/mbea_back.sv
// Back end: clears memory after reset, then read-modify-write per accumulate entry.
`timescale 1ns / 1ps
`default_nettype none
module mbea_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire mbea_pkg::entry_t                     head_i,
  input  wire logic                                 empty_i,
  output logic                                      pop_o,
  output logic                                      clearing_o,
  output logic                                      out_strobe_o,
  output logic [mbea_pkg::BUCKET_FIELD_W-1:0]       bucket_index_o,
  output logic [mbea_pkg::VALUE_W-1:0]              bucket_sum_o
);

  localparam int unsigned Depth = 2 ** mbea_pkg::BUCKET_BITS;

  logic [mbea_pkg::VALUE_W-1:0]     mem_q [Depth];
  logic [mbea_pkg::VALUE_W-1:0]     rdata_q;
  logic                             mem_we;
  logic [mbea_pkg::BUCKET_BITS-1:0] mem_waddr;
  logic [mbea_pkg::VALUE_W-1:0]     mem_wdata;

  logic                             state_q;
  logic                             state_d;
  logic [mbea_pkg::BUCKET_BITS-1:0] clr_addr_q;
  logic [mbea_pkg::BUCKET_BITS-1:0] clr_addr_d;
  logic                             s1_valid_q;
  mbea_pkg::entry_t                 s1_q;
  logic [mbea_pkg::VALUE_W-1:0]     sum;
  logic                             out_valid_q;
  logic [mbea_pkg::BUCKET_BITS-1:0] out_bucket_q;
  logic [mbea_pkg::VALUE_W-1:0]     out_sum_q;

  assign clearing_o     = (state_q == mbea_pkg::ST_CLEAR);
  assign pop_o          = (state_q == mbea_pkg::ST_RUN) && !empty_i && !s1_valid_q;
  assign sum            = s1_q.acc ? (rdata_q + s1_q.value) : rdata_q;
  assign out_strobe_o   = out_valid_q;
  assign bucket_index_o = mbea_pkg::BUCKET_FIELD_W'(out_bucket_q);
  assign bucket_sum_o   = out_sum_q;

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    mem_we     = 1'b0;
    mem_waddr  = s1_q.bucket;
    mem_wdata  = sum;
    case (state_q)
      mbea_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + mbea_pkg::BUCKET_BITS'(1);
        if (clr_addr_q == '1) begin
          state_d = mbea_pkg::ST_RUN;
        end
      end
      mbea_pkg::ST_RUN: begin
        mem_we = s1_valid_q && s1_q.acc;
      end
      default: begin
        state_d = mbea_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbea_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= pop_o;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= head_i;
    end
    if (s1_valid_q) begin
      out_bucket_q <= s1_q.bucket;
      out_sum_q    <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[head_i.bucket];
  end

endmodule
`default_nettype wire
